// ----- rtl/core/ttg_pkg.sv -----
`timescale 1ns / 1ps

package ttg_pkg;

	// Field widths
	localparam int NOW_W    = 32;
	localparam int POT_W    = 10;
	localparam int GAP_W    = 20;
	localparam int TICK_W   = 8;
	localparam int PERIOD_W = 17;

	// Shared divider widths: the pot product needs 25 bits, the period 17 bits
	localparam int DIV_NUM_W = 25;
	localparam int DIV_DEN_W = 17;

	// Accumulated time: remainder plus clamped gap
	localparam int TOTAL_W = 21;

	// Multiplier operand widths
	localparam int OFF_W   = 10;
	localparam int COEFF_W = 16;

	localparam logic [GAP_W-1:0] MAX_GAP_RESET = GAP_W'(1000000);
	localparam logic [TICK_W-1:0] TICK_MAX     = '1;

	// Pot segments
	localparam logic [POT_W-1:0] SEG1_START = POT_W'(128);
	localparam logic [POT_W-1:0] SEG2_START = POT_W'(895);

	localparam logic [PERIOD_W-1:0] SEG0_BASE = PERIOD_W'(83333);
	localparam logic [PERIOD_W-1:0] SEG1_BASE = PERIOD_W'(41666);
	localparam logic [PERIOD_W-1:0] SEG2_BASE = PERIOD_W'(12500);

	localparam logic [COEFF_W-1:0] SEG0_COEFF = COEFF_W'(41667);
	localparam logic [COEFF_W-1:0] SEG1_COEFF = COEFF_W'(29166);
	localparam logic [COEFF_W-1:0] SEG2_COEFF = COEFF_W'(8355);

	localparam logic [DIV_DEN_W-1:0] SEG0_DIV = DIV_DEN_W'(128);
	localparam logic [DIV_DEN_W-1:0] SEG1_DIV = DIV_DEN_W'(767);
	localparam logic [DIV_DEN_W-1:0] SEG2_DIV = DIV_DEN_W'(128);

	// Legal period range
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(4145);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(83333);

	typedef struct packed {
		logic [NOW_W-1:0] now_us;
		logic [POT_W-1:0] pot_value;
	} in_item_t;

	typedef struct packed {
		logic [TICK_W-1:0]   tick_count;
		logic [PERIOD_W-1:0] tick_period_us;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- rtl/core/ttg_div.sv -----
`timescale 1ns / 1ps

module ttg_div import ttg_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output div_status_t      status,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W-1:0] remainder
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// Form one restoring step: shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: load on start, advance one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

endmodule

// ----- rtl/core/tempo_tick_generator.sv -----
// Tempo tick generator. Each item carries a microsecond timestamp and a
// 10-bit tempo pot reading; the block answers with one item holding the tick
// period mapped from the pot (three linear segments) and the number of whole
// periods that fit in the time since the previous item plus the carried
// remainder, saturated at 255. Elapsed time wraps modulo 2^32 and is clamped
// to max_gap_us (reset value 1000000), written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block itself does
// not enforce this. All arithmetic runs through one multiplier and one shared
// radix-2 restoring divider that resolves one quotient bit per cycle while busy.
// The steps, in order: multiply and load the divider, divide for the period,
// load the divider again and divide for the ticks, then hand the result over.
// in_ready stays low from the accept until the result is handed over. A
// finished result waits in an output register, so the next item can be
// accepted before it is taken; only when the previous result is still waiting
// does the block hold its new result and stay busy longer.
`timescale 1ns / 1ps

module tempo_tick_generator import ttg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [GAP_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL   = 6'b000010,
		ST_DIVP  = 6'b000100,
		ST_LOADT = 6'b001000,
		ST_DIVT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [GAP_W-1:0]     max_gap_q;
	logic [NOW_W-1:0]     last_time_q;
	logic [PERIOD_W-1:0]  remainder_q;
	logic [POT_W-1:0]     pot_q;
	logic [GAP_W-1:0]     elapsed_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [TICK_W-1:0]    tick_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 accept;
	logic                 out_load;
	logic [NOW_W-1:0]     elapsed_raw;
	logic [GAP_W-1:0]     elapsed_clamped;
	logic                 in_seg0;
	logic                 in_seg2;
	logic [OFF_W-1:0]     off;
	logic [COEFF_W-1:0]   coeff;
	logic [DIV_DEN_W-1:0] seg_div;
	logic [PERIOD_W-1:0]  seg_base;
	logic [OFF_W+COEFF_W-1:0] prod_full;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_dividend;
	logic [DIV_DEN_W-1:0] div_divisor;
	div_status_t          div_st;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [DIV_DEN_W-1:0] div_rem;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Clamp elapsed time to the configured gap
	always_comb begin
		elapsed_raw = in_data.now_us - last_time_q;
		if (elapsed_raw > {{(NOW_W-GAP_W){1'b0}}, max_gap_q}) begin
			elapsed_clamped = max_gap_q;
		end else begin
			elapsed_clamped = elapsed_raw[GAP_W-1:0];
		end
	end

	// Pick the pot segment: offset, slope, divisor and base
	always_comb begin
		in_seg0 = (pot_q < SEG1_START);
		in_seg2 = (pot_q >= SEG2_START);
		if (in_seg0) begin
			off      = pot_q;
			coeff    = SEG0_COEFF;
			seg_div  = SEG0_DIV;
			seg_base = SEG0_BASE;
		end else if (in_seg2) begin
			off      = pot_q - SEG2_START;
			coeff    = SEG2_COEFF;
			seg_div  = SEG2_DIV;
			seg_base = SEG2_BASE;
		end else begin
			off      = pot_q - SEG1_START;
			coeff    = SEG1_COEFF;
			seg_div  = SEG1_DIV;
			seg_base = SEG1_BASE;
		end
		prod_full = off * coeff;
	end

	// Feed the shared divider
	always_comb begin
		div_start = (state_q == ST_MUL) || (state_q == ST_LOADT);
		if (state_q == ST_MUL) begin
			div_dividend = prod_full[DIV_NUM_W-1:0];
			div_divisor  = seg_div;
		end else begin
			div_dividend = {{(DIV_NUM_W-TOTAL_W){1'b0}}, total_q};
			div_divisor  = period_q;
		end
	end

	ttg_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.status    (div_st),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Hold the gap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= MAX_GAP_RESET;
		end else if (cfg_wr_en) begin
			max_gap_q <= cfg_wr_data;
		end
	end

	// Sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_time_q <= '0;
			remainder_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_time_q <= in_data.now_us;
						state_q     <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIVP;
				end
				ST_DIVP: begin
					if (div_st.done) begin
						state_q <= ST_LOADT;
					end
				end
				ST_LOADT: begin
					state_q <= ST_DIVT;
				end
				ST_DIVT: begin
					if (div_st.done) begin
						remainder_q <= div_rem;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pot_q     <= in_data.pot_value;
			elapsed_q <= elapsed_clamped;
		end
		if (state_q == ST_MUL) begin
			total_q <= TOTAL_W'(remainder_q) + TOTAL_W'(elapsed_q);
		end
		if ((state_q == ST_DIVP) && div_st.done) begin
			period_q <= seg_base - div_quo[PERIOD_W-1:0];
		end
		if ((state_q == ST_DIVT) && div_st.done) begin
			if (div_quo[DIV_NUM_W-1:TICK_W] != '0) begin
				tick_q <= TICK_MAX;
			end else begin
				tick_q <= div_quo[TICK_W-1:0];
			end
		end
		if (out_load) begin
			out_q.tick_count     <= tick_q;
			out_q.tick_period_us <= period_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/core/ttg_checker.sv -----
`timescale 1ns / 1ps

module ttg_checker import ttg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed or dropped while stalled");

	// Stay busy for the cycles after an accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input accepted again while an item is in work");

	// No result appears right after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result item appeared too early");

	// Keep the period inside the mapped range
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.tick_period_us >= PERIOD_MIN) &&
			(out_data.tick_period_us <= PERIOD_MAX))
		else $error("tick period out of range");

endmodule

bind tempo_tick_generator ttg_checker u_ttg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- tb/tb_tempo_tick_generator.sv -----
`timescale 1ns / 1ps

module tb_tempo_tick_generator;
	import ttg_pkg::*;

	localparam int RESET_CYCLES   = 10;
	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int MAX_PRINTS     = 40;

	typedef struct {
		logic [NOW_W-1:0]    now_us;
		logic [POT_W-1:0]    pot_value;
		bit                  typed;
		logic [TICK_W-1:0]   ticks;
		logic [PERIOD_W-1:0] period;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [GAP_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	// Predictor state
	logic [GAP_W-1:0]    gap_limit_us = MAX_GAP_RESET;
	logic [PERIOD_W-1:0] carry_us = '0;
	logic [NOW_W-1:0]    prev_now_us = '0;

	out_item_t pending_ticks[$];
	dir_row_t dir_rows[$];
	logic [NOW_W-1:0] last_sent_now = '0;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int updates_checked = 0;
	int saturated_seen = 0;
	int gap_settings = 0;
	int quiet_cycles = 0;

	tempo_tick_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Map the pot reading to a tick period, three linear segments
	function automatic logic [PERIOD_W-1:0] period_from_pot(logic [POT_W-1:0] pot);
		int unsigned x;
		int unsigned p;
		x = pot;
		if (x < int'(SEG1_START))
			p = 83333 - (x * 41667) / 128;
		else if (x < int'(SEG2_START))
			p = 41666 - ((x - 128) * 29166) / 767;
		else
			p = 12500 - ((x - 895) * 8355) / 128;
		return PERIOD_W'(p);
	endfunction

	// Advance the tick clock by one update and return the ticks it yields
	function automatic out_item_t advance_tick_clock(in_item_t item);
		out_item_t res;
		logic [NOW_W-1:0] elapsed;
		int unsigned period;
		int unsigned total;
		int unsigned ticks;
		period = period_from_pot(item.pot_value);
		elapsed = item.now_us - prev_now_us;
		prev_now_us = item.now_us;
		if (elapsed > NOW_W'(gap_limit_us))
			elapsed = NOW_W'(gap_limit_us);
		total = int'(carry_us) + elapsed;
		ticks = total / period;
		carry_us = PERIOD_W'(total % period);
		res.tick_count = (ticks > 255) ? TICK_MAX : TICK_W'(ticks);
		res.tick_period_us = PERIOD_W'(period);
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (error_count < MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic add_row(logic [NOW_W-1:0] now, logic [POT_W-1:0] pot, bit typed,
			logic [TICK_W-1:0] ticks, logic [PERIOD_W-1:0] period);
		dir_row_t r;
		r.now_us = now;
		r.pot_value = pot;
		r.typed = typed;
		r.ticks = ticks;
		r.period = period;
		dir_rows.push_back(r);
	endtask

	// Hold the item until accepted, then queue its expected ticks
	task automatic drive_item(in_item_t item, bit typed, out_item_t typed_res);
		out_item_t res;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		res = advance_tick_clock(item);
		if (typed)
			res = typed_res;
		pending_ticks.push_back(res);
		last_sent_now = item.now_us;
	endtask

	// Drain everything, then write the gap limit while the block is idle
	task automatic write_gap_limit(logic [GAP_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		gap_limit_us = value;
		gap_settings++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic in_item_t random_update();
		in_item_t item;
		case ($urandom_range(0, 9))
			0: item.now_us = $urandom();
			1: item.now_us = last_sent_now - $urandom_range(1, 1000);
			2: item.now_us = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			3, 4: item.now_us = last_sent_now + $urandom_range(0, 2000);
			default: item.now_us = last_sent_now + $urandom_range(0, 1200000);
		endcase
		case ($urandom_range(0, 11))
			0: item.pot_value = POT_W'(0);
			1: item.pot_value = POT_W'(127);
			2: item.pot_value = SEG1_START;
			3: item.pot_value = POT_W'(894);
			4: item.pot_value = SEG2_START;
			5: item.pot_value = POT_W'(1023);
			default: item.pot_value = POT_W'($urandom_range(0, 1023));
		endcase
		return item;
	endfunction

	// Drive the receiver side
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_ticks.size() == 0) begin
				report_mismatch("unexpected result item", out_data.tick_count, 0);
			end else begin
				want = pending_ticks.pop_front();
				if (out_data.tick_count !== want.tick_count)
					report_mismatch("tick_count", out_data.tick_count, want.tick_count);
				if (out_data.tick_period_us !== want.tick_period_us)
					report_mismatch("tick_period_us", out_data.tick_period_us,
						want.tick_period_us);
				updates_checked++;
				if (want.tick_count == TICK_MAX)
					saturated_seen++;
			end
		end
	end

	// Abort when no item moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		in_item_t item;
		out_item_t typed_res;
		logic [GAP_W-1:0] gap_value;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: segment ends, wrap, clamp, saturation
		add_row(32'd0,         10'd0,    1, 8'd0,   17'd83333);
		add_row(32'd83333,     10'd0,    1, 8'd1,   17'd83333);
		add_row(32'd83333,     10'd128,  1, 8'd0,   17'd41666);
		add_row(32'd208331,    10'd128,  1, 8'd3,   17'd41666);
		add_row(32'd233331,    10'd895,  1, 8'd2,   17'd12500);
		add_row(32'd254056,    10'd1023, 1, 8'd5,   17'd4145);
		add_row(32'hFFFF_FFFF, 10'd0,    1, 8'd12,  17'd83333);
		add_row(32'd83328,     10'd0,    1, 8'd1,   17'd83333);
		add_row(32'd166660,    10'd0,    1, 8'd0,   17'd83333);
		add_row(32'd1166660,   10'd1023, 1, 8'd255, 17'd4145);
		add_row(32'd1216660,   10'd127,  0, '0, '0);
		add_row(32'd1286660,   10'd894,  0, '0, '0);
		add_row(32'd1287660,   10'd1,    0, '0, '0);
		add_row(32'd1587660,   10'd512,  0, '0, '0);
		add_row(32'd1587663,   10'd1022, 0, '0, '0);
		add_row(32'h8000_0000, 10'd896,  0, '0, '0);
		add_row(32'h8000_4E20, 10'd255,  0, '0, '0);
		add_row(32'h8000_4E20, 10'd768,  0, '0, '0);
		add_row(32'h7FFF_FFFF, 10'd341,  0, '0, '0);
		add_row(32'hFFFF_FFF0, 10'd682,  0, '0, '0);
		add_row(32'h0000_0010, 10'd1023, 0, '0, '0);
		add_row(32'h5555_5555, 10'h2AA,  0, '0, '0);
		add_row(32'hAAAA_AAAA, 10'h155,  0, '0, '0);

		foreach (dir_rows[i]) begin
			item.now_us = dir_rows[i].now_us;
			item.pot_value = dir_rows[i].pot_value;
			typed_res.tick_count = dir_rows[i].ticks;
			typed_res.tick_period_us = dir_rows[i].period;
			drive_item(item, dir_rows[i].typed, typed_res);
		end

		// Random phases, each setting a gap limit and an idling pattern
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0, 6: gap_value = '1;
				1: gap_value = GAP_W'(1);
				2: gap_value = '0;
				4: gap_value = MAX_GAP_RESET;
				5: gap_value = GAP_W'($urandom_range(1, 100000));
				default: gap_value = GAP_W'($urandom_range(1, 1048575));
			endcase
			write_gap_limit(gap_value);
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_gap_pct = 15;
					recv_stall_pct = 15;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				drive_item(random_update(), 0, typed_res);
		end

		// Drain and settle
		in_valid <= 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_ticks.size() != 0)
			report_mismatch("results never returned", 0, pending_ticks.size());

		$display("Checked %0d tick updates across %0d gap limit settings and four idling patterns,",
			updates_checked, gap_settings);
		$display("including %0d updates saturated at the maximum tick count.", saturated_seen);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
